### hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

	localparam int unsigned ENTRIES_DEF    = 8;
	localparam int unsigned KEY_BITS_DEF   = 64;
	localparam int unsigned VALUE_BITS_DEF = 64;
	localparam int unsigned FIELD_BITS     = 64;
	localparam int unsigned CAP_BITS       = 4;
	localparam int unsigned MODE_BITS      = 2;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

endpackage

### hw/rtl/lkvc_front.sv
module lkvc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lkvc_pkg::MODE_BITS-1:0]   mode,
	input  logic [lkvc_pkg::FIELD_BITS-1:0]  key,
	input  logic [lkvc_pkg::FIELD_BITS-1:0]  value,
	output logic                             q_valid,
	input  logic                             q_pop,
	output logic [lkvc_pkg::MODE_BITS-1:0]   q_mode,
	output logic [lkvc_pkg::FIELD_BITS-1:0]  q_key,
	output logic [lkvc_pkg::FIELD_BITS-1:0]  q_value
);
	import lkvc_pkg::*;

	// Two-entry queue; the mode is classified on entry so that unknown codes become no-ops.
	logic [MODE_BITS-1:0]  mode_q [2];
	logic [FIELD_BITS-1:0] key_q  [2];
	logic [FIELD_BITS-1:0] val_q  [2];
	logic                  wr_q, rd_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic [MODE_BITS-1:0]  mode_c;

	always_comb begin
		case (mode)
			MODE_LOOKUP, MODE_INSERT, MODE_REMOVE: mode_c = mode;
			default: mode_c = MODE_NOP;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_mode   = mode_q[rd_q];
	assign q_key    = key_q[rd_q];
	assign q_value  = val_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mode_q[wr_q] <= mode_c;
			key_q[wr_q]  <= key;
			val_q[wr_q]  <= value;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> in_stall) else $error("full queue not stalling");

endmodule

### hw/rtl/lkvc_back.sv
module lkvc_back #(
	parameter int unsigned ENTRIES    = lkvc_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lkvc_pkg::CAP_BITS-1:0]    cap_q,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  logic [lkvc_pkg::MODE_BITS-1:0]   q_mode,
	input  logic [lkvc_pkg::FIELD_BITS-1:0]  q_key,
	input  logic [lkvc_pkg::FIELD_BITS-1:0]  q_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic [lkvc_pkg::FIELD_BITS-1:0]  value_out,
	output logic                             evicted,
	output logic                             busy
);
	import lkvc_pkg::*;

	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic                  vld_q [ENTRIES];
	logic [KEY_BITS-1:0]   key_q [ENTRIES];
	logic [VALUE_BITS-1:0] val_q [ENTRIES];
	logic [AW-1:0]         age_q [ENTRIES];
	logic [CW-1:0]         count_q;

	logic [KEY_BITS-1:0]   k;
	logic [ENTRIES-1:0]    match;
	logic                  found;
	logic [AW-1:0]         hslot, oslot, fslot;
	logic                  ffound, ofound;
	logic [CW-1:0]         cap_eff;
	logic                  full, do_evict, take;
	logic [AW-1:0]         hage, oage;

	assign k = q_key[KEY_BITS-1:0];

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end
	assign full = (count_q >= cap_eff);

	// Key match, oldest entry (age count-1) and first free slot.
	always_comb begin
		found  = 1'b0;
		hslot  = '0;
		ofound = 1'b0;
		oslot  = '0;
		ffound = 1'b0;
		fslot  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = vld_q[i] && (key_q[i] == k);
			if (match[i]) begin
				found = 1'b1;
				hslot = AW'(i);
			end
			if (vld_q[i] && (CW'(age_q[i]) == count_q - CW'(1))) begin
				ofound = 1'b1;
				oslot  = AW'(i);
			end
			if (!vld_q[i] && !ffound) begin
				ffound = 1'b1;
				fslot  = AW'(i);
			end
		end
	end

	assign take     = q_valid && (!out_valid || !out_stall);
	assign q_pop    = take;
	assign busy     = q_valid || out_valid;
	assign do_evict = !found && full && ofound &&
		(q_mode == MODE_LOOKUP || q_mode == MODE_INSERT);
	assign hage = age_q[hslot];
	assign oage = age_q[oslot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			count_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				vld_q[i] <= 1'b0;
				age_q[i] <= '0;
			end
		end else begin
			if (take) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (take) begin
				case (q_mode)
					MODE_LOOKUP: begin
						if (found) begin
							for (int i = 0; i < ENTRIES; i++) begin
								if (vld_q[i] && age_q[i] < hage) begin
									age_q[i] <= age_q[i] + AW'(1);
								end
							end
							age_q[hslot] <= '0;
						end else if (do_evict) begin
							vld_q[oslot] <= 1'b0;
							count_q <= count_q - CW'(1);
						end
					end
					MODE_INSERT: begin
						// Old copy or oldest leaves; survivors older than it shift
						// down then all shift up, so only younger ones move.
						for (int i = 0; i < ENTRIES; i++) begin
							if (vld_q[i]) begin
								if (found ? (age_q[i] < hage) :
									!(do_evict && age_q[i] >= oage)) begin
									age_q[i] <= age_q[i] + AW'(1);
								end
							end
						end
						if (found) begin
							vld_q[hslot] <= 1'b1;
							age_q[hslot] <= '0;
						end else if (do_evict) begin
							vld_q[oslot] <= 1'b1;
							age_q[oslot] <= '0;
						end else if (ffound) begin
							vld_q[fslot] <= 1'b1;
							age_q[fslot] <= '0;
							count_q <= count_q + CW'(1);
						end
					end
					MODE_REMOVE: begin
						if (found) begin
							vld_q[hslot] <= 1'b0;
							count_q <= count_q - CW'(1);
							for (int i = 0; i < ENTRIES; i++) begin
								if (vld_q[i] && age_q[i] > hage) begin
									age_q[i] <= age_q[i] - AW'(1);
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Insert reuses the matched, evicted or first free slot. Which slot holds a pair
	// cannot be seen from outside, so any free slot gives the same behaviour.
	always_ff @(posedge clk) begin
		if (take) begin
			hit       <= found && (q_mode != MODE_NOP);
			evicted   <= do_evict;
			value_out <= (q_mode == MODE_LOOKUP && found) ?
				FIELD_BITS'(val_q[hslot]) : '0;
			if (q_mode == MODE_INSERT) begin
				if (found) begin
					key_q[hslot] <= k;
					val_q[hslot] <= q_value[VALUE_BITS-1:0];
				end else if (do_evict) begin
					key_q[oslot] <= k;
					val_q[oslot] <= q_value[VALUE_BITS-1:0];
				end else begin
					key_q[fslot] <= k;
					val_q[fslot] <= q_value[VALUE_BITS-1:0];
				end
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= ENTRIES) else $error("entry count above depth");
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match)) else $error("duplicate key in cache");
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		do_evict |-> !found) else $error("eviction on a hit");

endmodule

### hw/rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement. Each item
// carries a mode (lookup, insert, remove, no-op), a key and a value, and yields exactly
// one result item with hit, value_out and evicted. A front queue of two items takes
// requests while the back end works; the back end compares the key against every entry
// combinationally, so a request is handled directly from the queue head and its result
// leaves through an output register, giving one item per cycle sustained while the output
// is not stalled. The capacity register may be written only while the block is idle;
// cfg_ready is low while any item is in flight. No clearing pass is needed after reset.
module lru_key_value_cache #(
	parameter int unsigned ENTRIES    = lkvc_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lkvc_pkg::MODE_BITS-1:0]   mode,
	input  logic [lkvc_pkg::FIELD_BITS-1:0]  key,
	input  logic [lkvc_pkg::FIELD_BITS-1:0]  value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic [lkvc_pkg::FIELD_BITS-1:0]  value_out,
	output logic                             evicted,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lkvc_pkg::CAP_BITS-1:0]    cache_capacity
);
	import lkvc_pkg::*;

	logic                  q_valid, q_pop, busy;
	logic [MODE_BITS-1:0]  q_mode;
	logic [FIELD_BITS-1:0] q_key, q_value;
	logic [CAP_BITS-1:0]   cap_q;

	// The capacity register is written only when nothing is in flight.
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cache_capacity;
		end
	end

	lkvc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .key, .value,
		.q_valid, .q_pop, .q_mode, .q_key, .q_value
	);

	lkvc_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk, .arst_n, .cap_q, .q_valid, .q_pop, .q_mode, .q_key, .q_value,
		.out_valid, .out_stall, .hit, .value_out, .evicted, .busy
	);

endmodule
